>>> rtl/kes_pkg.sv
// Package for the Kepler equation solver: widths, constants, datapath command and status types, arctangent table.
// No dependencies.
package kes_pkg;
  localparam int AngleW = 32;
  localparam int EccW = 30;
  localparam int TolW = 20;
  localparam int IterW = 10;
  localparam int CordicSteps = 30;
  localparam int StepW = 5;
  localparam int DivSteps = 36;
  localparam int DivCntW = 6;
  localparam int IterMax = 1000;

  localparam logic signed [63:0] PiQ30 = 64'sd3373259426;
  localparam logic signed [63:0] HalfPiQ30 = 64'sd1686629713;
  localparam logic signed [63:0] TwoPiQ30 = 64'sd6746518852;
  localparam logic signed [63:0] GainQ30 = 64'sd652032874;
  localparam logic signed [63:0] OneQ30 = 64'sd1073741824;

  typedef struct packed {
    logic load;
    logic start;
  } kes_cmd_t;

  typedef struct packed {
    logic busy;
    logic step_done;
    logic last_done;
  } kes_sts_t;

  function automatic logic signed [63:0] atan_q30(input logic [StepW-1:0] i);
    logic signed [63:0] v;
    case (i)
      5'd0: v = 64'sd843314857;
      5'd1: v = 64'sd497837829;
      5'd2: v = 64'sd263043837;
      5'd3: v = 64'sd133525159;
      5'd4: v = 64'sd67021687;
      5'd5: v = 64'sd33543516;
      5'd6: v = 64'sd16775851;
      5'd7: v = 64'sd8388437;
      5'd8: v = 64'sd4194283;
      5'd9: v = 64'sd2097149;
      5'd31: v = 64'sd1;
      default: v = 64'sd1 <<< (5'd30 - i);
    endcase
    return v;
  endfunction
endpackage

>>> rtl/kes_datapath.sv
// Datapath of the Kepler equation solver: angle reduction, CORDIC, products, restoring divider, update, saturation.
// Depends on kes_pkg.
module kes_datapath (
  input  logic                          clk,
  input  logic                          rst_n,
  input  kes_pkg::kes_cmd_t             cmd,
  output kes_pkg::kes_sts_t             sts,
  input  logic signed [kes_pkg::AngleW-1:0] m_in,
  input  logic [kes_pkg::EccW-1:0]      ecc_in,
  input  logic [kes_pkg::TolW-1:0]      tol,
  output logic signed [kes_pkg::AngleW-1:0] e_out,
  output logic                          conv_out
);
  localparam logic [3:0] P_IDLE = 4'd0, P_RED = 4'd1, P_COR = 4'd2, P_MUL = 4'd3,
    P_RND = 4'd4, P_FD = 4'd5, P_DIV = 4'd6, P_UPD = 4'd7, P_SAT = 4'd8;

  logic [3:0] ph_r, ph_nxt;
  logic signed [kes_pkg::AngleW-1:0] m_r, e_r;
  logic [kes_pkg::EccW-1:0] ecc_r;
  logic signed [63:0] x_r, y_r, z_r, ps_r, pc_r, f_r, d_r, nx_r;
  logic [kes_pkg::StepW-1:0] i_r;
  logic flip_r, neg_r, conv_r, sat_r;
  logic [63:0] rem_r, quo_r, den_r;
  logic [kes_pkg::DivCntW-1:0] dc_r;

  logic signed [63:0] e30, m30, tr, sx, sy, es, ec, step, diff;
  logic [63:0] rsh, quo_sh, smag, mag;
  logic [64:0] rtry;
  logic signed [31:0] ymul, xmul;
  logic signed [30:0] emul;
  logic signed [62:0] ps_w, pc_w;

  assign e30 = 64'(e_r) <<< 2;
  assign m30 = 64'(m_r) <<< 2;
  assign sx = x_r >>> i_r;
  assign sy = y_r >>> i_r;
  assign es = (ps_r + 64'sd536870912) >>> 30;
  assign ec = (pc_r + 64'sd536870912) >>> 30;
  assign rsh = {rem_r[62:0], quo_r[63]};
  assign rtry = {1'b0, rsh} - {1'b0, den_r};
  assign quo_sh = {quo_r[62:0], 1'b0};
  assign mag = f_r[63] ? 64'(-f_r) : 64'(f_r);
  assign emul = {1'b0, ecc_r};
  assign ymul = flip_r ? -y_r[31:0] : y_r[31:0];
  assign xmul = flip_r ? -x_r[31:0] : x_r[31:0];
  assign ps_w = emul * ymul;
  assign pc_w = emul * xmul;

  always_comb begin
    ph_nxt = ph_r;
    unique case (ph_r)
      P_IDLE: if (cmd.start) ph_nxt = P_RED;
      P_RED: if (z_r <= kes_pkg::PiQ30 && z_r >= -kes_pkg::PiQ30) ph_nxt = P_COR;
      P_COR: if (i_r == 5'(kes_pkg::CordicSteps - 1)) ph_nxt = P_MUL;
      P_MUL: ph_nxt = P_RND;
      P_RND: ph_nxt = P_FD;
      P_FD: ph_nxt = P_DIV;
      P_DIV: if (dc_r == 6'(kes_pkg::DivSteps - 1)) ph_nxt = P_UPD;
      P_UPD: ph_nxt = P_SAT;
      P_SAT: ph_nxt = P_IDLE;
      default: ph_nxt = P_IDLE;
    endcase
  end

  always_comb begin
    smag = sat_r ? (64'd64 << 30) : quo_r;
    step = neg_r ? -$signed(smag) : $signed(smag);
    tr = (step + 64'sd2) >>> 2;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= P_IDLE;
    end else begin
      ph_r <= ph_nxt;
    end
    if (cmd.load) begin
      m_r <= m_in;
      e_r <= m_in;
      ecc_r <= ecc_in;
    end
    unique case (ph_r)
      P_IDLE: begin
        z_r <= e30;
        x_r <= kes_pkg::GainQ30;
        y_r <= '0;
        i_r <= '0;
        flip_r <= 1'b0;
      end
      P_RED: begin
        if (z_r > kes_pkg::PiQ30) z_r <= z_r - kes_pkg::TwoPiQ30;
        else if (z_r < -kes_pkg::PiQ30) z_r <= z_r + kes_pkg::TwoPiQ30;
        else if (z_r > kes_pkg::HalfPiQ30) begin
          z_r <= z_r - kes_pkg::PiQ30;
          flip_r <= 1'b1;
        end else if (z_r < -kes_pkg::HalfPiQ30) begin
          z_r <= z_r + kes_pkg::PiQ30;
          flip_r <= 1'b1;
        end
      end
      P_COR: begin
        if (z_r >= 0) begin
          x_r <= x_r - sy;
          y_r <= y_r + sx;
          z_r <= z_r - kes_pkg::atan_q30(i_r);
        end else begin
          x_r <= x_r + sy;
          y_r <= y_r - sx;
          z_r <= z_r + kes_pkg::atan_q30(i_r);
        end
        i_r <= i_r + 5'd1;
      end
      P_MUL: begin
        ps_r <= 64'(ps_w);
        pc_r <= 64'(pc_w);
      end
      P_RND: begin
        f_r <= e30 - es - m30;
        d_r <= (kes_pkg::OneQ30 - ec < 64'sd1) ? 64'sd1 : kes_pkg::OneQ30 - ec;
      end
      P_FD: begin
        neg_r <= f_r[63];
        sat_r <= (mag >= (64'(d_r) << 6));
        rem_r <= mag >> 6;
        quo_r <= {mag[5:0], 58'd0};
        den_r <= 64'(d_r);
        dc_r <= '0;
      end
      P_DIV: begin
        dc_r <= dc_r + 6'd1;
        if (!rtry[64]) begin
          rem_r <= rtry[63:0];
          quo_r <= quo_sh | 64'd1;
        end else begin
          rem_r <= rsh;
          quo_r <= quo_sh;
        end
      end
      P_UPD: nx_r <= 64'(e_r) - tr;
      P_SAT: begin
        if (nx_r > 64'sd2147483647) e_r <= 32'sh7fffffff;
        else if (nx_r < -64'sd2147483648) e_r <= 32'sh80000000;
        else e_r <= nx_r[31:0];
        conv_r <= (diff <= $signed(64'(tol))) && (diff >= -$signed(64'(tol)));
      end
      default: ;
    endcase
  end

  always_comb begin
    if (nx_r > 64'sd2147483647) diff = 64'sd2147483647 - 64'(e_r);
    else if (nx_r < -64'sd2147483648) diff = -64'sd2147483648 - 64'(e_r);
    else diff = nx_r - 64'(e_r);
  end

  assign sts.busy = (ph_r != P_IDLE);
  assign sts.step_done = (ph_r == P_SAT);
  assign sts.last_done = conv_r;
  assign e_out = e_r;
  assign conv_out = conv_r;
endmodule

>>> rtl/kes_ctrl.sv
// Controller of the Kepler equation solver: item handshake and Newton step count.
// Depends on kes_pkg.
module kes_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  logic [kes_pkg::IterW-1:0] max_iter,
  input  logic                      conv_now,
  output logic [kes_pkg::IterW-1:0] iters,
  output kes_pkg::kes_cmd_t         cmd,
  input  kes_pkg::kes_sts_t         sts
);
  localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_WAIT = 2'd2, S_OUT = 2'd3;
  logic [1:0] st_r, st_nxt;
  logic [kes_pkg::IterW-1:0] it_r, it_nxt, lim;

  always_comb begin
    lim = max_iter;
    if (lim == '0) lim = 10'd1;
    if (lim > 10'(kes_pkg::IterMax)) lim = 10'(kes_pkg::IterMax);
  end

  always_comb begin
    st_nxt = st_r;
    it_nxt = it_r;
    cmd.load = 1'b0;
    cmd.start = 1'b0;
    unique case (st_r)
      S_IDLE: if (in_fire) begin
        cmd.load = 1'b1;
        it_nxt = '0;
        st_nxt = S_RUN;
      end
      S_RUN: begin
        cmd.start = 1'b1;
        st_nxt = S_WAIT;
      end
      S_WAIT: if (sts.step_done) begin
        it_nxt = it_r + 10'd1;
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!sts.last_done && it_r < lim) st_nxt = S_RUN;
        else if (out_ready) st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      it_r <= '0;
    end else begin
      st_r <= st_nxt;
      it_r <= it_nxt;
    end
  end

  assign in_ready = (st_r == S_IDLE);
  assign out_valid = (st_r == S_OUT) && (conv_now || it_r >= lim);
  assign iters = it_r;
endmodule

>>> rtl/kepler_equation_solver_unit.sv
// Kepler equation solver top level: configuration registers, controller and datapath.
// Each Newton step runs angle reduction, CORDIC, products, rounding, the restoring divider, update
// and saturation, in that order.
// The result word is valid after iterations_used Newton steps once the input word is accepted;
// the next word is accepted in the cycle after the result word leaves. One word per solve.
// Reset is synchronous and active low; it sets tolerance 1 and max_iterations 1000.
// Depends on kes_pkg, kes_ctrl and kes_datapath.
module kepler_equation_solver_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // mean_anomaly [31:0], eccentricity [61:32]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // eccentric_anomaly [31:0], iterations_used [41:32], converged [42]
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);
  localparam logic CfgTol = 1'b0, CfgMaxIt = 1'b1;
  logic [kes_pkg::TolW-1:0] tol_r;
  logic [kes_pkg::IterW-1:0] maxit_r, iters;
  logic signed [kes_pkg::AngleW-1:0] e_out;
  logic conv;
  kes_pkg::kes_cmd_t cmd;
  kes_pkg::kes_sts_t sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= 20'd1;
      maxit_r <= 10'd1000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgTol: tol_r <= cfg_wdata;
        CfgMaxIt: maxit_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  kes_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_tvalid && in_tready), .in_ready(in_tready),
    .out_valid(out_tvalid), .out_ready(out_tready), .max_iter(maxit_r),
    .conv_now(conv), .iters(iters), .cmd(cmd), .sts(sts)
  );

  kes_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .m_in(in_tdata[31:0]),
    .ecc_in(in_tdata[61:32]), .tol(tol_r), .e_out(e_out), .conv_out(conv)
  );

  assign out_tdata = {5'd0, conv, iters, e_out};
endmodule
